// ===== design/rrcfb_pkg.sv =====
// ----------------------------------------------------------------------------
// rrcfb_pkg
// shared widths, register indexes and defaults for the rectangle fill/blend
// ----------------------------------------------------------------------------
package rrcfb_pkg;

    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int CH_W    = 8;
    localparam int CTRL_W  = 3;
    localparam int COLOR_W = 24;
    localparam int IDX_W   = 3;
    localparam int PROD_W  = 2 * CH_W;

    localparam int MAX_DIM_DEF = 4096;

    // register indexes of the configuration port
    typedef enum logic [IDX_W-1:0] {
        CFG_LEFT   = 3'd0,
        CFG_TOP    = 3'd1,
        CFG_RIGHT  = 3'd2,
        CFG_BOTTOM = 3'd3,
        CFG_WIDTH  = 3'd4,
        CFG_HEIGHT = 3'd5,
        CFG_CTRL   = 3'd6,
        CFG_COLOR  = 3'd7
    } t_cfg_idx;

    // control register bits
    localparam int CTRL_ALPHA_MODE = 0;
    localparam int CTRL_OUTSIDE    = 1;
    localparam int CTRL_ALPHA_OK   = 2;

endpackage

// ===== design/rect_region_color_fill_blend.sv =====
// ----------------------------------------------------------------------------
// rect_region_color_fill_blend
// letterbox fill of a rectangular window (or its border) with a solid color
// or an alpha blend of that color; without stalls, one rgba pixel per clock
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake               payload
//  --------  ---  ----------------------  -----------------------------------
//  pixel in  in   i_in_valid / o_in_stall   i_pix_x, i_pix_y, i_in_red/green/
//                                           blue/alpha
//  pixel out out  o_out_valid / i_out_stall o_out_red/green/blue/alpha
//  config    in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  one pixel per clock sustained while the output is not stalled; three
//  register stages (window compare, products, blend sum plus output
//  register), which a pixel passes in turn before o_out_valid rises
//  synchronous active-low reset clears the stage valid bits and loads the
//  register defaults (frame size 1, everything else 0)
//  each stage moves when it is empty or the stage after it moves, so a stall
//  on the output backs up stage by stage without dropping or repeating pixels
//  o_cfg_ready is always high; registers may be written only while idle
//
module rect_region_color_fill_blend #(
    parameter int MAX_DIM = rrcfb_pkg::MAX_DIM_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // pixel input
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [rrcfb_pkg::COORD_W-1:0]    i_pix_x,
    input  logic [rrcfb_pkg::COORD_W-1:0]    i_pix_y,
    input  logic [rrcfb_pkg::CH_W-1:0]       i_in_red,
    input  logic [rrcfb_pkg::CH_W-1:0]       i_in_green,
    input  logic [rrcfb_pkg::CH_W-1:0]       i_in_blue,
    input  logic [rrcfb_pkg::CH_W-1:0]       i_in_alpha,
    // pixel output
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [rrcfb_pkg::CH_W-1:0]       o_out_red,
    output logic [rrcfb_pkg::CH_W-1:0]       o_out_green,
    output logic [rrcfb_pkg::CH_W-1:0]       o_out_blue,
    output logic [rrcfb_pkg::CH_W-1:0]       o_out_alpha,
    // register writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rrcfb_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [rrcfb_pkg::COLOR_W-1:0]    i_cfg_data
);

    localparam int COORD_W = rrcfb_pkg::COORD_W;
    localparam int DIM_W   = rrcfb_pkg::DIM_W;
    localparam int CH_W    = rrcfb_pkg::CH_W;
    localparam int CTRL_W  = rrcfb_pkg::CTRL_W;
    localparam int COLOR_W = rrcfb_pkg::COLOR_W;
    localparam int PROD_W  = rrcfb_pkg::PROD_W;
    localparam logic [31:0] MAX_DIM_U = 32'(MAX_DIM);
    localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] r_left, r_top, r_right, r_bottom;
    logic [DIM_W-1:0]   r_width, r_height;
    logic [CTRL_W-1:0]  r_ctrl;
    logic [COLOR_W-1:0] r_color;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_right  <= '0;
            r_bottom <= '0;
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
            r_ctrl   <= '0;
            r_color  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (rrcfb_pkg::t_cfg_idx'(i_cfg_index))
                rrcfb_pkg::CFG_LEFT:   r_left   <= i_cfg_data[COORD_W-1:0];
                rrcfb_pkg::CFG_TOP:    r_top    <= i_cfg_data[COORD_W-1:0];
                rrcfb_pkg::CFG_RIGHT:  r_right  <= i_cfg_data[COORD_W-1:0];
                rrcfb_pkg::CFG_BOTTOM: r_bottom <= i_cfg_data[COORD_W-1:0];
                rrcfb_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                rrcfb_pkg::CFG_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                rrcfb_pkg::CFG_CTRL:   r_ctrl   <= i_cfg_data[CTRL_W-1:0];
                rrcfb_pkg::CFG_COLOR:  r_color  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // frame size clamped to the largest supported dimension
    logic [DIM_W-1:0] w_clamp, h_clamp;
    assign w_clamp = ({{(32-DIM_W){1'b0}}, r_width} > MAX_DIM_U)
                     ? MAX_DIM_U[DIM_W-1:0] : r_width;
    assign h_clamp = ({{(32-DIM_W){1'b0}}, r_height} > MAX_DIM_U)
                     ? MAX_DIM_U[DIM_W-1:0] : r_height;

    logic alpha_mode, fill_out, alpha_ok;
    assign alpha_mode = r_ctrl[rrcfb_pkg::CTRL_ALPHA_MODE];
    assign fill_out   = r_ctrl[rrcfb_pkg::CTRL_OUTSIDE];
    assign alpha_ok   = r_ctrl[rrcfb_pkg::CTRL_ALPHA_OK];

    // fill color split into channels: red low, blue high
    logic [CH_W-1:0] col [3];
    assign col[0] = r_color[CH_W-1:0];
    assign col[1] = r_color[2*CH_W-1:CH_W];
    assign col[2] = r_color[3*CH_W-1:2*CH_W];

    // ------------------------------------------------------------------
    // stage enables: a stage loads when it is empty or drains this cycle
    // ------------------------------------------------------------------
    logic r_s1_v, r_s2_v, r_out_v;
    logic en_out, en_s2, en_s1;

    assign en_out     = !r_out_v || !i_out_stall;
    assign en_s2      = !r_s2_v || en_out;
    assign en_s1      = !r_s1_v || en_s2;
    assign o_in_stall = !en_s1;

    // ------------------------------------------------------------------
    // stage 1: capture pixel, frame/margin checks and low window edges
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] r_s1_x, r_s1_y;
    logic [CH_W-1:0]    r_s1_ch [3];
    logic [CH_W-1:0]    r_s1_a;
    logic               r_s1_act, r_s1_lo_ok;
    logic               n_s1_act, n_s1_lo_ok;
    logic [DIM_W-1:0]   sum_lr, sum_tb;

    assign sum_lr = {1'b0, r_left} + {1'b0, r_right};
    assign sum_tb = {1'b0, r_top} + {1'b0, r_bottom};

    always_comb begin
        // pass-through cases: no window, bad alpha setup, pixel off frame
        n_s1_act = !(alpha_mode && !alpha_ok)
                   && (sum_lr < w_clamp) && (sum_tb < h_clamp)
                   && ({1'b0, i_pix_x} < w_clamp) && ({1'b0, i_pix_y} < h_clamp);
        n_s1_lo_ok = (i_pix_x >= r_left) && (i_pix_y >= r_top);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en_s1) begin
            r_s1_v <= i_in_valid;
        end
        if (en_s1) begin
            r_s1_x     <= i_pix_x;
            r_s1_y     <= i_pix_y;
            r_s1_ch[0] <= i_in_red;
            r_s1_ch[1] <= i_in_green;
            r_s1_ch[2] <= i_in_blue;
            r_s1_a     <= i_in_alpha;
            r_s1_act   <= n_s1_act;
            r_s1_lo_ok <= n_s1_lo_ok;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: high window edges, fill decision, blend products
    // ------------------------------------------------------------------
    logic [CH_W-1:0]   r_s2_ch [3];
    logic [CH_W-1:0]   r_s2_a;
    logic [PROD_W-1:0] r_s2_pp [3];   // pixel * (255 - a)
    logic [PROD_W-1:0] r_s2_pc [3];   // color * a
    logic              r_s2_fill;
    logic              n_s2_fill, in_win;
    logic [DIM_W-1:0]  x_end, y_end;
    logic [CH_W-1:0]   inv_a;

    // x < w - right, written without the subtraction; the wrap case is
    // already excluded because left + right < w
    assign x_end = {1'b0, r_s1_x} + {1'b0, r_right};
    assign y_end = {1'b0, r_s1_y} + {1'b0, r_bottom};
    assign inv_a = CH_MAX - r_s1_a;

    always_comb begin
        in_win    = r_s1_lo_ok && (x_end < w_clamp) && (y_end < h_clamp);
        n_s2_fill = r_s1_act && (fill_out ? !in_win : in_win);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en_s2) begin
            r_s2_v <= r_s1_v;
        end
        if (en_s2) begin
            r_s2_a    <= r_s1_a;
            r_s2_fill <= n_s2_fill;
            for (int i = 0; i < 3; i++) begin
                r_s2_ch[i] <= r_s1_ch[i];
                r_s2_pp[i] <= {{CH_W{1'b0}}, r_s1_ch[i]} * {{CH_W{1'b0}}, inv_a};
                r_s2_pc[i] <= {{CH_W{1'b0}}, col[i]} * {{CH_W{1'b0}}, r_s1_a};
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 3: blend sum, channel select, output register
    // ------------------------------------------------------------------
    logic [CH_W-1:0]   r_out_ch [3];
    logic [CH_W-1:0]   r_out_a;
    logic [CH_W-1:0]   n_out_ch [3];
    logic [PROD_W-1:0] blend_sum [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // max 255*255 + 255 still fits in 16 bits
            blend_sum[i] = r_s2_pp[i] + r_s2_pc[i] + PROD_W'(CH_MAX);
            if (!r_s2_fill) begin
                n_out_ch[i] = r_s2_ch[i];
            end else if (alpha_mode) begin
                n_out_ch[i] = blend_sum[i][PROD_W-1:CH_W];
            end else begin
                n_out_ch[i] = col[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en_out) begin
            r_out_v <= r_s2_v;
        end
        if (en_out) begin
            r_out_a <= r_s2_a;
            for (int i = 0; i < 3; i++) begin
                r_out_ch[i] <= n_out_ch[i];
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_red   = r_out_ch[0];
    assign o_out_green = r_out_ch[1];
    assign o_out_blue  = r_out_ch[2];
    assign o_out_alpha = r_out_a;

endmodule

// ===== design/rrcfb_checker.sv =====
// ----------------------------------------------------------------------------
// rrcfb_checker
// port-level checks for the rectangle fill/blend pipeline
// ----------------------------------------------------------------------------
module rrcfb_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic [rrcfb_pkg::COORD_W-1:0] i_pix_x,
    input logic [rrcfb_pkg::COORD_W-1:0] i_pix_y,
    input logic [rrcfb_pkg::CH_W-1:0]    i_in_red,
    input logic [rrcfb_pkg::CH_W-1:0]    i_in_green,
    input logic [rrcfb_pkg::CH_W-1:0]    i_in_blue,
    input logic [rrcfb_pkg::CH_W-1:0]    i_in_alpha,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [rrcfb_pkg::CH_W-1:0]    o_out_red,
    input logic [rrcfb_pkg::CH_W-1:0]    o_out_green,
    input logic [rrcfb_pkg::CH_W-1:0]    o_out_blue,
    input logic [rrcfb_pkg::CH_W-1:0]    o_out_alpha,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [rrcfb_pkg::IDX_W-1:0]   i_cfg_index,
    input logic [rrcfb_pkg::COLOR_W-1:0] i_cfg_data
);

    // stalled output transfer holds its pixel
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_red)
        && $stable(o_out_green) && $stable(o_out_blue) && $stable(o_out_alpha))
        else $error("output changed while stalled");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // an empty output register never backs up the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with output empty");

    // a transferred pixel passes stage 1, stage 2 and the output register in
    // turn and reaches the output when the output is not stalled on the way
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 (!i_out_stall && i_rst_n)
        ##1 (!i_out_stall && i_rst_n) |=> o_out_valid)
        else $error("pixel lost in pipeline");

    // register writes are never held off
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write refused");

endmodule

bind rect_region_color_fill_blend rrcfb_checker u_rrcfb_checker (.*);

// ===== test/tb_rect_region_color_fill_blend.sv =====
// ----------------------------------------------------------------------------
// tb_rect_region_color_fill_blend
// self-checking bench for the rectangle fill/blend: a queue-fed pixel driver,
// a result monitor and a local color predictor, run under directed corner
// cases and randomized register setups with random idling on both sides
// ----------------------------------------------------------------------------
module tb_rect_region_color_fill_blend;
    import rrcfb_pkg::*;

    localparam int LATENCY          = 3;
    localparam int HOLD_CYCLES      = 80;
    localparam int HOLD_FIRST       = 300;
    localparam int HOLD_SPACING     = 700;
    localparam int SETUPS_PER_MODE  = 8;
    localparam int PIXELS_PER_SETUP = 80;
    localparam int QUIET_LIMIT      = 20000;
    localparam int COORD_MAX        = (1 << COORD_W) - 1;

    // control register values built from the package bit positions
    localparam logic [CTRL_W-1:0] CTRL_SOLID_IN = '0;
    localparam logic [CTRL_W-1:0] CTRL_BLEND    = CTRL_W'(1 << CTRL_ALPHA_MODE);
    localparam logic [CTRL_W-1:0] CTRL_BORDER   = CTRL_W'(1 << CTRL_OUTSIDE);
    localparam logic [CTRL_W-1:0] CTRL_AVALID   = CTRL_W'(1 << CTRL_ALPHA_OK);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CH_W-1:0]    red;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    blue;
        logic [CH_W-1:0]    alpha;
    } pixel_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } rgba_t;

    // ports, every input known from time zero
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    pixel_t             offer       = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [CH_W-1:0]    o_out_red;
    logic [CH_W-1:0]    o_out_green;
    logic [CH_W-1:0]    o_out_blue;
    logic [CH_W-1:0]    o_out_alpha;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    t_cfg_idx           i_cfg_index = CFG_LEFT;
    logic [COLOR_W-1:0] i_cfg_data  = '0;

    // shadow copy of the register file, reset values
    logic [COORD_W-1:0] shadow_left   = '0;
    logic [COORD_W-1:0] shadow_top    = '0;
    logic [COORD_W-1:0] shadow_right  = '0;
    logic [COORD_W-1:0] shadow_bottom = '0;
    logic [DIM_W-1:0]   shadow_width  = 1;
    logic [DIM_W-1:0]   shadow_height = 1;
    logic [CTRL_W-1:0]  shadow_ctrl   = '0;
    logic [COLOR_W-1:0] shadow_color  = '0;

    // pixels waiting to be offered, and colors waiting to come out
    pixel_t pending_pixels[$];
    rgba_t  expected_colors[$];
    rgba_t  want;

    int sender_idle_pct   = 13;
    int receiver_idle_pct = 45;
    int pixels_sent       = 0;
    int results_checked   = 0;
    int setups_run        = 0;
    int holds_done        = 0;
    int hold_left         = 0;
    int next_hold_at      = HOLD_FIRST;
    int errors            = 0;

    rect_region_color_fill_blend DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_pix_x     (offer.x),
        .i_pix_y     (offer.y),
        .i_in_red    (offer.red),
        .i_in_green  (offer.green),
        .i_in_blue   (offer.blue),
        .i_in_alpha  (offer.alpha),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_alpha (o_out_alpha),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // color predictor
    // ------------------------------------------------------------------------

    // frame sizes beyond the supported maximum behave as the maximum
    function automatic int clamp_dim(int d);
        return (d > MAX_DIM_DEF) ? MAX_DIM_DEF : d;
    endfunction

    // rounded weighted mix of pixel channel and fill channel by the pixel alpha
    function automatic logic [CH_W-1:0] mix_channel(logic [CH_W-1:0] ch,
                                                    logic [CH_W-1:0] col,
                                                    logic [CH_W-1:0] a);
        int sum;
        sum = int'(ch) * (255 - int'(a)) + int'(col) * int'(a) + 255;
        return CH_W'(sum >> 8);
    endfunction

    function automatic rgba_t shade_pixel(pixel_t p);
        int    w;
        int    h;
        int    lm;
        int    rm;
        int    tm;
        int    bm;
        int    px;
        int    py;
        logic  blend;
        logic  live;
        logic  in_win;
        rgba_t o;
        w      = clamp_dim(int'(shadow_width));
        h      = clamp_dim(int'(shadow_height));
        lm     = int'(shadow_left);
        rm     = int'(shadow_right);
        tm     = int'(shadow_top);
        bm     = int'(shadow_bottom);
        px     = int'(p.x);
        py     = int'(p.y);
        blend  = shadow_ctrl[CTRL_ALPHA_MODE];
        o      = '{p.red, p.green, p.blue, p.alpha};
        // blend without a usable alpha, empty window or off-frame pixel: untouched
        live   = !(blend && !shadow_ctrl[CTRL_ALPHA_OK]) && (lm + rm < w) &&
                 (tm + bm < h) && (px < w) && (py < h);
        in_win = (px >= lm) && (px < w - rm) && (py >= tm) && (py < h - bm);
        if (live && (in_win != shadow_ctrl[CTRL_OUTSIDE])) begin
            if (blend) begin
                o.red   = mix_channel(p.red,   shadow_color[CH_W-1:0],        p.alpha);
                o.green = mix_channel(p.green, shadow_color[2*CH_W-1:CH_W],   p.alpha);
                o.blue  = mix_channel(p.blue,  shadow_color[3*CH_W-1:2*CH_W], p.alpha);
            end else begin
                o.red   = shadow_color[CH_W-1:0];
                o.green = shadow_color[2*CH_W-1:CH_W];
                o.blue  = shadow_color[3*CH_W-1:2*CH_W];
            end
        end
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // error reporting
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_channel(string name, logic [CH_W-1:0] got,
                                 logic [CH_W-1:0] exp_val);
        if (got !== exp_val) begin
            flag_mismatch($sformatf("result %0d %s: got %0h, predicted %0h",
                                    results_checked, name, got, exp_val));
        end
    endtask

    // ------------------------------------------------------------------------
    // pixel driver: one transfer per accepted edge, next pixel from the queue
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            // transfer at this edge: predict with the registers now in force
            if (i_in_valid && !o_in_stall) begin
                expected_colors.push_back(shade_pixel(offer));
                pixels_sent <= pixels_sent + 1;
            end
            // a stalled pixel stays put; otherwise offer the next or idle
            if (!i_in_valid || !o_in_stall) begin
                if (pending_pixels.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct) begin
                    offer      <= pending_pixels.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // output stall: random idling plus long holds that back up the pipeline
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (pixels_sent >= next_hold_at) begin
            // long hold while the driver keeps offering, so the input stalls too
            i_out_stall  <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + HOLD_SPACING;
            holds_done   <= holds_done + 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: each output transfer against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_colors.size() == 0) begin
                flag_mismatch("output transfer with no pixel outstanding");
            end else begin
                want = expected_colors.pop_front();
                check_channel("red",   o_out_red,   want.red);
                check_channel("green", o_out_green, want.green);
                check_channel("blue",  o_out_blue,  want.blue);
                check_channel("alpha", o_out_alpha, want.alpha);
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one register write transfer, then update the shadow copy
    task automatic write_reg(t_cfg_idx idx, logic [COLOR_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_LEFT:   shadow_left   = value[COORD_W-1:0];
            CFG_TOP:    shadow_top    = value[COORD_W-1:0];
            CFG_RIGHT:  shadow_right  = value[COORD_W-1:0];
            CFG_BOTTOM: shadow_bottom = value[COORD_W-1:0];
            CFG_WIDTH:  shadow_width  = value[DIM_W-1:0];
            CFG_HEIGHT: shadow_height = value[DIM_W-1:0];
            CFG_CTRL:   shadow_ctrl   = value[CTRL_W-1:0];
            CFG_COLOR:  shadow_color  = value;
            default: ;
        endcase
    endtask

    task automatic queue_pixel(int x, int y, int r, int g, int b, int a);
        pending_pixels.push_back(pixel_t'{COORD_W'(x), COORD_W'(y), CH_W'(r),
                                          CH_W'(g), CH_W'(b), CH_W'(a)});
    endtask

    // block idle: nothing queued, nothing offered, nothing outstanding
    task automatic wait_quiet();
        int spin;
        spin = 0;
        while ((pending_pixels.size() != 0 || i_in_valid ||
                expected_colors.size() != 0) && spin < QUIET_LIMIT) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // mostly small frames, now and then the extremes of the register
    function automatic int pick_dim();
        int r;
        r = $urandom_range(15);
        if (r == 0) begin
            case ($urandom_range(4))
                0:       return 0;
                1:       return MAX_DIM_DEF;
                2:       return MAX_DIM_DEF + 1;
                3:       return MAX_DIM_DEF - 1;
                default: return (1 << DIM_W) - 1;
            endcase
        end
        if (r == 1) return $urandom_range(1, (1 << DIM_W) - 1);
        return $urandom_range(1, 48);
    endfunction

    function automatic int pick_margin(int dim);
        int r;
        r = $urandom_range(9);
        if (r == 0) return 0;
        if (r == 1) return COORD_MAX;
        if (r == 2) return $urandom_range(COORD_MAX);
        return $urandom_range(0, clamp_dim(dim) / 2);
    endfunction

    // coordinate mostly inside or just past the frame, sometimes anywhere
    function automatic int pick_coord(int dim);
        int top_end;
        top_end = clamp_dim(dim) + 2;
        if (top_end > COORD_MAX) top_end = COORD_MAX;
        if ($urandom_range(4) == 0) return $urandom_range(COORD_MAX);
        return $urandom_range(0, top_end);
    endfunction

    function automatic int pick_alpha();
        case ($urandom_range(7))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    task automatic random_setup();
        int w;
        int h;
        int c;
        w = pick_dim();
        h = pick_dim();
        case ($urandom_range(7))
            0:       c = 0;
            1:       c = (1 << COLOR_W) - 1;
            default: c = $urandom_range((1 << COLOR_W) - 1);
        endcase
        write_reg(CFG_LEFT,   pick_margin(w));
        write_reg(CFG_TOP,    pick_margin(h));
        write_reg(CFG_RIGHT,  pick_margin(w));
        write_reg(CFG_BOTTOM, pick_margin(h));
        write_reg(CFG_WIDTH,  w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_CTRL,   $urandom_range((1 << CTRL_W) - 1));
        write_reg(CFG_COLOR,  c);
        setups_run++;
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        int mode;
        int s;
        int n;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults: one-pixel frame, solid black fill inside
        queue_pixel(0, 0, 8'h12, 8'h34, 8'h56, 8'h78);
        queue_pixel(0, 0, 255, 255, 255, 255);
        queue_pixel(1, 0, 8'h9a, 8'hbc, 8'hde, 8'hf0);
        queue_pixel(COORD_MAX, COORD_MAX, 255, 255, 255, 255);
        wait_quiet();

        // 16x12 frame, window columns 2..12, rows 1..9, solid fill inside
        write_reg(CFG_LEFT, 2);
        write_reg(CFG_TOP, 1);
        write_reg(CFG_RIGHT, 3);
        write_reg(CFG_BOTTOM, 2);
        write_reg(CFG_WIDTH, 16);
        write_reg(CFG_HEIGHT, 12);
        write_reg(CFG_CTRL, CTRL_SOLID_IN);
        write_reg(CFG_COLOR, 24'hf03ca5);
        setups_run++;
        queue_pixel(2, 1, 0, 0, 0, 0);
        queue_pixel(1, 5, 1, 2, 3, 4);
        queue_pixel(12, 9, 255, 255, 255, 255);
        queue_pixel(13, 5, 10, 20, 30, 40);
        queue_pixel(5, 10, 50, 60, 70, 80);
        queue_pixel(15, 11, 90, 100, 110, 120);
        wait_quiet();

        // blended border fill with valid alpha, alpha at both ends
        write_reg(CFG_CTRL, CTRL_BLEND | CTRL_BORDER | CTRL_AVALID);
        queue_pixel(0, 0, 8'h80, 8'h40, 8'hff, 0);
        queue_pixel(15, 11, 8'h00, 8'hff, 8'h55, 255);
        queue_pixel(1, 1, 8'haa, 8'h55, 8'h01, 128);
        queue_pixel(6, 5, 8'h11, 8'h22, 8'h33, 200);
        wait_quiet();

        // blend requested without valid alpha: everything passes
        write_reg(CFG_CTRL, CTRL_BLEND);
        queue_pixel(2, 1, 8'h61, 8'h62, 8'h63, 100);
        queue_pixel(0, 0, 8'h71, 8'h72, 8'h73, 255);
        wait_quiet();

        // empty horizontal window, then empty vertical window, border mode
        write_reg(CFG_CTRL, CTRL_BORDER);
        write_reg(CFG_LEFT, 8);
        write_reg(CFG_RIGHT, 8);
        queue_pixel(0, 0, 1, 1, 1, 1);
        queue_pixel(8, 5, 2, 2, 2, 2);
        wait_quiet();
        write_reg(CFG_LEFT, 2);
        write_reg(CFG_RIGHT, 3);
        write_reg(CFG_TOP, 6);
        write_reg(CFG_BOTTOM, 6);
        queue_pixel(0, 0, 3, 3, 3, 3);
        queue_pixel(5, 5, 4, 4, 4, 4);
        wait_quiet();

        // oversized frame clamps to the maximum, window is the last column
        write_reg(CFG_WIDTH, (1 << DIM_W) - 1);
        write_reg(CFG_HEIGHT, MAX_DIM_DEF + 1);
        write_reg(CFG_LEFT, COORD_MAX);
        write_reg(CFG_RIGHT, 0);
        write_reg(CFG_TOP, 0);
        write_reg(CFG_BOTTOM, 0);
        write_reg(CFG_CTRL, CTRL_SOLID_IN);
        write_reg(CFG_COLOR, 24'hffffff);
        queue_pixel(COORD_MAX, COORD_MAX, 0, 0, 0, 9);
        queue_pixel(COORD_MAX - 1, 100, 0, 0, 0, 9);
        wait_quiet();

        // zero width, then zero height
        write_reg(CFG_WIDTH, 0);
        queue_pixel(0, 0, 5, 6, 7, 8);
        wait_quiet();
        write_reg(CFG_WIDTH, 16);
        write_reg(CFG_HEIGHT, 0);
        queue_pixel(0, 0, 9, 10, 11, 12);
        wait_quiet();

        // random setups under three idle patterns
        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    sender_idle_pct   = 13;
                    receiver_idle_pct = 45;
                end
                1: begin
                    sender_idle_pct   = 45;
                    receiver_idle_pct = 13;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            for (s = 0; s < SETUPS_PER_MODE; s++) begin
                random_setup();
                for (n = 0; n < PIXELS_PER_SETUP; n++) begin
                    queue_pixel(pick_coord(int'(shadow_width)),
                                pick_coord(int'(shadow_height)),
                                $urandom_range(255), $urandom_range(255),
                                $urandom_range(255), pick_alpha());
                end
                // sender waits here until every result of the setup is back
                wait_quiet();
            end
        end

        wait_quiet();
        if (expected_colors.size() != 0) begin
            flag_mismatch($sformatf("%0d predicted pixels never came out",
                                    expected_colors.size()));
        end
        $display("checked %0d of %0d pixels over %0d register setups, %0d long output holds",
                 results_checked, pixels_sent, setups_run, holds_done);
        $display("covered inside and border fill, solid and blend, empty windows, clamped sizes");
        if (errors == 0) begin
            $display("tb_rect_region_color_fill_blend: PASS");
        end else begin
            $display("tb_rect_region_color_fill_blend: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("tb_rect_region_color_fill_blend: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/rrcfb_pkg.sv
design/rect_region_color_fill_blend.sv
design/rrcfb_checker.sv
test/tb_rect_region_color_fill_blend.sv
